>>> src/esdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package esdt_pkg;
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FieldW = 32;
  localparam int unsigned DistW = 63;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 63;
  localparam logic [DistW-1:0] Sat63 = {DistW{1'b1}};

  typedef enum logic [1:0] {
    CmdOffer = 2'd0,
    CmdRead  = 2'd1,
    CmdClear = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OutRejected = 3'd0,
    OutReplaced = 3'd1,
    OutKept     = 3'd2,
    OutAppended = 3'd3,
    OutFull     = 3'd4,
    OutReadOk   = 3'd5,
    OutBadSlot  = 3'd6,
    OutCleared  = 3'd7
  } outcome_e;

  typedef enum logic [2:0] {
    CfgTargetX = 3'd0,
    CfgTargetY = 3'd1,
    CfgTargetZ = 3'd2,
    CfgMode    = 3'd3,
    CfgTol     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeMin = 2'd0,
    ModeMax = 2'd1,
    ModeAll = 2'd2,
    ModeAlt = 2'd3
  } mode_e;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StDistX,
    StDistY,
    StDistZ,
    StFilter,
    StScanRd,
    StScanU,
    StScanV,
    StScanCmp,
    StWrite,
    StReadWait,
    StDone
  } state_e;

  // Operand select for the shared square-accumulate unit
  typedef struct packed {
    logic        start;
    logic        clear;
    logic [32:0] diff;
  } sq_ctrl_t;

  // Saturating add of two 63-bit values
  function automatic logic [DistW-1:0] sat_add(input logic [DistW-1:0] a,
                                               input logic [DistW-1:0] b);
    logic [DistW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DistW] ? Sat63 : s[DistW-1:0];
  endfunction
endpackage
`default_nettype wire

>>> src/esdt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module esdt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> src/esdt_sqacc.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared unit: square one 33-bit difference (magnitude <= 2^32) and add
// it, saturated, into an accumulator. One square per cycle.
module esdt_sqacc (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire esdt_pkg::sq_ctrl_t ctrl_i,
  output logic [esdt_pkg::DistW-1:0] acc_o
);
  import esdt_pkg::*;

  logic [32:0]      mag;
  logic [65:0]      prod;
  logic [DistW-1:0] sq;
  logic [DistW-1:0] acc_d, acc_q;

  always_comb begin
    mag   = ctrl_i.diff[32] ? (~ctrl_i.diff + 33'd1) : ctrl_i.diff;
    prod  = mag * mag;
    sq    = (|prod[65:DistW]) ? Sat63 : prod[DistW-1:0];
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.start) begin
      acc_d = sat_add(acc_q, sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

>>> src/extremum_solution_dedup_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Deduplicating table of extremum solutions. Each command taken on start
// returns one result on done_o for one cycle; the receiver cannot stall.
// A clear or unknown command goes straight to the done state, a read
// through the read-wait state. An offer squares the three distance terms
// and filters, then scans each stored slot (memory read, u and v squares
// through the single shared multiplier, compare), then does the final
// check, write-back and result. busy is high throughout.
module extremum_solution_dedup_table #(
  parameter int unsigned TABLE_DEPTH = esdt_pkg::TableDepthDef,
  parameter int unsigned COORD_WIDTH = esdt_pkg::CoordWidthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [esdt_pkg::CfgAddrW-1:0]   cfg_index_i,
  input  wire logic [esdt_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      command_i,
  input  wire logic signed [31:0]              param_u_i,
  input  wire logic signed [31:0]              param_v_i,
  input  wire logic signed [31:0]              point_x_i,
  input  wire logic signed [31:0]              point_y_i,
  input  wire logic signed [31:0]              point_z_i,
  input  wire logic [5:0]                      read_slot_i,
  output logic                                 done_o,
  output logic [2:0]                           outcome_o,
  output logic [6:0]                           entry_count_o,
  output logic [5:0]                           entry_slot_o,
  output logic signed [31:0]                   entry_u_o,
  output logic signed [31:0]                   entry_v_o,
  output logic signed [31:0]                   entry_x_o,
  output logic signed [31:0]                   entry_y_o,
  output logic signed [31:0]                   entry_z_o,
  output logic [esdt_pkg::DistW-1:0]           entry_sq_distance_o
);
  import esdt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RamW = 5 * FieldW + DistW;

  // configuration
  logic signed [32:0] tgt_x_q, tgt_y_q, tgt_z_q;
  logic [1:0]         mode_q;
  logic [DistW-1:0]   tol_q;

  function automatic logic signed [32:0] sx(input logic [31:0] v);
    logic [COORD_WIDTH-1:0] t;
    t = v[COORD_WIDTH-1:0];
    return 33'(signed'(t));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      tgt_z_q <= '0;
      mode_q  <= ModeAll;
      tol_q   <= DistW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgTargetX: tgt_x_q <= sx(cfg_data_i[31:0]);
        CfgTargetY: tgt_y_q <= sx(cfg_data_i[31:0]);
        CfgTargetZ: tgt_z_q <= sx(cfg_data_i[31:0]);
        CfgMode:    mode_q  <= cfg_data_i[1:0];
        CfgTol:     tol_q   <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // transaction capture
  logic [1:0]         cmd_q;
  logic signed [32:0] u_q, v_q, x_q, y_q, z_q;
  logic [5:0]         rslot_q;
  logic [DistW-1:0]   d_q, best_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  state_e             state_q, state_d;
  logic               reject_seen_q;

  // result registers
  logic [2:0]       res_out_q;
  logic [6:0]       res_cnt_q;
  logic [5:0]       res_slot_q;
  logic             res_entry_q;
  logic             done_q;

  // table memory
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [RamW-1:0]  ram_wdata, ram_rdata;

  esdt_ram #(.Width(RamW), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic signed [32:0] slot_u, slot_v;
  logic [DistW-1:0]   slot_d;
  assign slot_u = 33'(signed'(ram_rdata[RamW-1 -: 32]));
  assign slot_v = 33'(signed'(ram_rdata[RamW-33 -: 32]));
  assign slot_d = ram_rdata[DistW-1:0];

  sq_ctrl_t         sq_ctrl;
  logic [DistW-1:0] acc;

  esdt_sqacc u_sq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(sq_ctrl),
    .acc_o (acc)
  );

  // filter decision uses the fresh accumulator value
  logic [DistW-1:0] d_filter;
  assign d_filter = acc;

  logic is_min, is_max, reject, match, better, full;
  assign is_min = (mode_q == ModeMin);
  assign is_max = (mode_q == ModeMax);
  assign reject = (is_min && d_filter > best_q) || (is_max && d_filter < best_q);
  assign match  = (acc <= tol_q);
  assign better = (is_min && d_q < slot_d) || (is_max && d_q > slot_d);
  assign full   = (count_q >= CW'(TABLE_DEPTH));

  logic accept_in;
  assign accept_in = start && !busy;
  assign busy = (state_q != StIdle);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept_in) begin
          unique case (cmd_e'(command_i))
            CmdOffer: state_d = StDistX;
            CmdRead:  state_d = StReadWait;
            default:  state_d = StDone;
          endcase
        end
      end
      StDistX:  state_d = StDistY;
      StDistY:  state_d = StDistZ;
      StDistZ:  state_d = StFilter;
      StFilter: state_d = reject ? StDone : StScanRd;
      StScanRd: state_d = (idx_q >= count_q) ? (full ? StDone : StWrite) : StScanU;
      StScanU:  state_d = StScanV;
      StScanV:  state_d = StScanCmp;
      StScanCmp: state_d = match ? (better ? StWrite : StDone) : StScanRd;
      StWrite:  state_d = StDone;
      StReadWait: state_d = StDone;
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // datapath control
  always_comb begin
    sq_ctrl   = '0;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_raddr = idx_q[AW-1:0];
    ram_wdata = {u_q[31:0], v_q[31:0], x_q[31:0], y_q[31:0], z_q[31:0], d_q};
    unique case (state_q)
      StIdle:  sq_ctrl.clear = 1'b1;
      StDistX: begin sq_ctrl.start = 1'b1; sq_ctrl.diff = x_q - tgt_x_q; end
      StDistY: begin sq_ctrl.start = 1'b1; sq_ctrl.diff = y_q - tgt_y_q; end
      StDistZ: begin sq_ctrl.start = 1'b1; sq_ctrl.diff = z_q - tgt_z_q; end
      StFilter, StScanRd: sq_ctrl.clear = 1'b1;
      StScanU: begin sq_ctrl.start = 1'b1; sq_ctrl.diff = u_q - slot_u; end
      StScanV: begin sq_ctrl.start = 1'b1; sq_ctrl.diff = v_q - slot_v; end
      StWrite: ram_we = 1'b1;
      StReadWait: ram_raddr = rslot_q[AW-1:0];
      default: ;
    endcase
    if (state_q == StIdle && cmd_e'(command_i) == CmdRead) begin
      ram_raddr = AW'(read_slot_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      best_q      <= Sat63;
      idx_q       <= '0;
      done_q      <= 1'b0;
      res_entry_q <= 1'b0;
      res_out_q   <= OutRejected;
      res_cnt_q   <= '0;
      res_slot_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StDone);
      unique case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (accept_in) begin
            res_entry_q <= 1'b0;
            if (cmd_e'(command_i) == CmdClear) begin
              count_q   <= '0;
              best_q    <= (mode_q == ModeMin) ? Sat63 : '0;
              res_out_q <= OutCleared;
              res_cnt_q <= '0;
            end else begin
              res_out_q <= OutRejected;
              res_cnt_q <= 7'(count_q);
            end
          end
        end
        StDistZ: ;
        StFilter: begin
          d_q <= acc;
          // acc is the point distance this cycle
        end
        default: ;
      endcase
      if (state_q == StScanRd && idx_q >= count_q) begin
        if (full) begin
          res_out_q <= OutFull;
        end else begin
          res_out_q   <= OutAppended;
          res_entry_q <= 1'b1;
          res_slot_q  <= 6'(idx_q);
          res_cnt_q   <= 7'(count_q + CW'(1));
          count_q     <= count_q + CW'(1);
        end
      end
      if (state_q == StScanCmp) begin
        if (match) begin
          res_slot_q  <= 6'(idx_q);
          res_entry_q <= 1'b1;
          res_out_q   <= better ? OutReplaced : OutKept;
        end else begin
          idx_q <= idx_q + CW'(1);
        end
      end
      if (state_q == StReadWait) begin
        if (CW'(rslot_q) < count_q && 7'(rslot_q) < 7'(count_q)) begin
          res_out_q   <= OutReadOk;
          res_entry_q <= 1'b1;
          res_slot_q  <= rslot_q;
        end else begin
          res_out_q <= OutBadSlot;
        end
      end
      if (state_q == StScanRd && idx_q == '0 && !reject_seen_q) begin
        best_q <= d_q;
      end
    end
  end

  // per offer, the best update happens once, at the first scan step after the filter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_seen_q <= 1'b0;
    end else if (state_q == StFilter) begin
      reject_seen_q <= 1'b0;
    end else if (state_q == StScanRd) begin
      reject_seen_q <= 1'b1;
    end
  end

  // payload capture; distance taken from the accumulator at filter time
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cmd_q   <= command_i;
      u_q     <= sx(param_u_i);
      v_q     <= sx(param_v_i);
      x_q     <= sx(point_x_i);
      y_q     <= sx(point_y_i);
      z_q     <= sx(point_z_i);
      rslot_q <= read_slot_i;
    end
  end

  // hold a copy of the written or read entry for the result
  logic [RamW-1:0] res_data_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StWrite) begin
      res_data_q <= ram_wdata;
    end else if (state_q == StReadWait || state_q == StScanCmp) begin
      res_data_q <= ram_rdata;
    end
  end

  assign done_o        = done_q;
  assign outcome_o     = res_out_q;
  assign entry_count_o = res_cnt_q;
  assign entry_slot_o  = res_entry_q ? res_slot_q : '0;
  assign entry_u_o     = res_entry_q ? res_data_q[RamW-1 -: 32] : '0;
  assign entry_v_o     = res_entry_q ? res_data_q[RamW-33 -: 32] : '0;
  assign entry_x_o     = res_entry_q ? res_data_q[RamW-65 -: 32] : '0;
  assign entry_y_o     = res_entry_q ? res_data_q[RamW-97 -: 32] : '0;
  assign entry_z_o     = res_entry_q ? res_data_q[RamW-129 -: 32] : '0;
  assign entry_sq_distance_o = res_entry_q ? res_data_q[DistW-1:0] : '0;

  logic unused;
  assign unused = ^{cmd_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("count overflow");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy) else $error("table written while idle");
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScanU) |-> (idx_q < count_q)) else $error("scan past count");
`endif
endmodule
`default_nettype wire
